>>> hdl/dhcp_tlv_pkg.sv
// Shared types and constants for the DHCP options TLV parser.
// Used by the parser core, the result buffer and the top level; no dependencies.
`default_nettype none

package dhcp_tlv_pkg;

    // Option codes that the parser acts on.
    localparam logic [7:0] OPT_PAD       = 8'd0;
    localparam logic [7:0] OPT_SUBNET    = 8'd1;
    localparam logic [7:0] OPT_ROUTER    = 8'd3;
    localparam logic [7:0] OPT_DNS       = 8'd6;
    localparam logic [7:0] OPT_LEASE     = 8'd51;
    localparam logic [7:0] OPT_MSG_TYPE  = 8'd53;
    localparam logic [7:0] OPT_SERVER_ID = 8'd54;
    localparam logic [7:0] OPT_RENEW     = 8'd58;
    localparam logic [7:0] OPT_REBIND    = 8'd59;
    localparam logic [7:0] OPT_END       = 8'd255;

    // Number of 32-bit values kept and their slots in the found mask.
    localparam int NUM_SLOTS = 7;
    localparam logic [2:0] SLOT_SUBNET    = 3'd0;
    localparam logic [2:0] SLOT_ROUTER    = 3'd1;
    localparam logic [2:0] SLOT_DNS       = 3'd2;
    localparam logic [2:0] SLOT_LEASE     = 3'd3;
    localparam logic [2:0] SLOT_SERVER_ID = 3'd4;
    localparam logic [2:0] SLOT_RENEW     = 3'd5;
    localparam logic [2:0] SLOT_REBIND    = 3'd6;

    // Value bytes kept per option and the required lengths.
    localparam logic [7:0] VALUE_BYTES  = 8'd4;
    localparam logic [7:0] MSG_TYPE_LEN = 8'd1;

    // Width of the packed result on the output stream.
    localparam int RESULT_BITS = 8 + NUM_SLOTS * 32 + NUM_SLOTS;
    localparam int RESULT_TDATA_BITS = ((RESULT_BITS + 7) / 8) * 8;

    // Walker phase, one-hot.
    typedef enum logic [3:0] {
        PH_TYPE  = 4'b0001,
        PH_LEN   = 4'b0010,
        PH_VALUE = 4'b0100,
        PH_DONE  = 4'b1000
    } phase_t;

    // One result item.
    typedef struct packed {
        logic [NUM_SLOTS-1:0]             found_mask;
        logic [NUM_SLOTS-1:0][31:0]       values;
        logic [7:0]                       message_type;
    } result_t;

    // Occupancy of the result buffer.
    typedef struct packed {
        logic out_valid;
        logic skid_valid;
    } buf_status_t;

endpackage

`default_nettype wire

>>> hdl/dhcp_tlv_core.sv
// Parser core: walker state registers and the per-byte next-state logic.
// Depends on dhcp_tlv_pkg for option codes, phase type and result struct.
`default_nettype none

module dhcp_tlv_core (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  byte_fire,
    input  wire logic [7:0]            data_byte,
    input  wire logic                  last_byte,
    output logic                       res_valid,
    output dhcp_tlv_pkg::result_t      res_data,
    output dhcp_tlv_pkg::phase_t       phase
);

    dhcp_tlv_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  opt_reg, opt_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  seen_reg, seen_next;
    logic [7:0]  seen_inc;
    logic [31:0] acc_reg, acc_next;
    logic [7:0]  mtype_reg, mtype_next;
    logic [dhcp_tlv_pkg::NUM_SLOTS-1:0][31:0] vals_reg, vals_next;
    logic [dhcp_tlv_pkg::NUM_SLOTS-1:0]       found_reg, found_next;
    logic        commit;
    logic        slot_ok;
    logic [2:0]  slot_sel;

    // Walk one byte through the record state.
    always_comb
    begin
        phase_next = phase_reg;
        opt_next   = opt_reg;
        len_next   = len_reg;
        seen_next  = seen_reg;
        acc_next   = acc_reg;
        commit     = 1'b0;
        seen_inc   = seen_reg + 8'd1;
        unique case (phase_reg)
            dhcp_tlv_pkg::PH_TYPE:
            begin
                if (data_byte == dhcp_tlv_pkg::OPT_END) begin
                    phase_next = dhcp_tlv_pkg::PH_DONE;
                end else if (data_byte != dhcp_tlv_pkg::OPT_PAD) begin
                    opt_next   = data_byte;
                    phase_next = dhcp_tlv_pkg::PH_LEN;
                end
            end
            dhcp_tlv_pkg::PH_LEN:
            begin
                len_next  = data_byte;
                seen_next = 8'd0;
                acc_next  = 32'd0;
                // A zero-length record ends here and never qualifies.
                if (data_byte == 8'd0) begin
                    phase_next = dhcp_tlv_pkg::PH_TYPE;
                end else begin
                    phase_next = dhcp_tlv_pkg::PH_VALUE;
                end
            end
            dhcp_tlv_pkg::PH_VALUE:
            begin
                if (seen_reg < dhcp_tlv_pkg::VALUE_BYTES) begin
                    acc_next = {acc_reg[23:0], data_byte};
                end
                seen_next = seen_inc;
                if (seen_inc >= len_reg) begin
                    commit     = 1'b1;
                    phase_next = dhcp_tlv_pkg::PH_TYPE;
                end
            end
            dhcp_tlv_pkg::PH_DONE:
            begin
                phase_next = dhcp_tlv_pkg::PH_DONE;
            end
            default:
            begin
                phase_next = dhcp_tlv_pkg::PH_TYPE;
            end
        endcase
    end

    // Decide where a finished record goes and whether its length qualifies.
    always_comb
    begin
        slot_sel   = dhcp_tlv_pkg::SLOT_SUBNET;
        slot_ok    = 1'b0;
        mtype_next = mtype_reg;
        vals_next  = vals_reg;
        found_next = found_reg;
        unique case (opt_reg)
            dhcp_tlv_pkg::OPT_MSG_TYPE:
            begin
                if (commit && len_reg == dhcp_tlv_pkg::MSG_TYPE_LEN) begin
                    mtype_next = acc_next[7:0];
                end
            end
            dhcp_tlv_pkg::OPT_SUBNET:
            begin
                slot_sel = dhcp_tlv_pkg::SLOT_SUBNET;
                slot_ok  = (len_reg == dhcp_tlv_pkg::VALUE_BYTES);
            end
            dhcp_tlv_pkg::OPT_ROUTER:
            begin
                slot_sel = dhcp_tlv_pkg::SLOT_ROUTER;
                slot_ok  = (len_reg >= dhcp_tlv_pkg::VALUE_BYTES);
            end
            dhcp_tlv_pkg::OPT_DNS:
            begin
                slot_sel = dhcp_tlv_pkg::SLOT_DNS;
                slot_ok  = (len_reg >= dhcp_tlv_pkg::VALUE_BYTES);
            end
            dhcp_tlv_pkg::OPT_LEASE:
            begin
                slot_sel = dhcp_tlv_pkg::SLOT_LEASE;
                slot_ok  = (len_reg == dhcp_tlv_pkg::VALUE_BYTES);
            end
            dhcp_tlv_pkg::OPT_SERVER_ID:
            begin
                slot_sel = dhcp_tlv_pkg::SLOT_SERVER_ID;
                slot_ok  = (len_reg == dhcp_tlv_pkg::VALUE_BYTES);
            end
            dhcp_tlv_pkg::OPT_RENEW:
            begin
                slot_sel = dhcp_tlv_pkg::SLOT_RENEW;
                slot_ok  = (len_reg == dhcp_tlv_pkg::VALUE_BYTES);
            end
            dhcp_tlv_pkg::OPT_REBIND:
            begin
                slot_sel = dhcp_tlv_pkg::SLOT_REBIND;
                slot_ok  = (len_reg == dhcp_tlv_pkg::VALUE_BYTES);
            end
            default:
            begin
                slot_ok = 1'b0;
            end
        endcase
        if (commit && slot_ok) begin
            vals_next[slot_sel]  = acc_next;
            found_next[slot_sel] = 1'b1;
        end
    end

    // The result leaves with the final byte, built from the updated state.
    assign res_valid             = byte_fire && last_byte;
    assign res_data.message_type = mtype_next;
    assign res_data.values       = vals_next;
    assign res_data.found_mask   = found_next;
    assign phase                 = phase_reg;

    // State registers; the final byte returns everything to reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= dhcp_tlv_pkg::PH_TYPE;
            opt_reg   <= 8'd0;
            len_reg   <= 8'd0;
            seen_reg  <= 8'd0;
            acc_reg   <= 32'd0;
            mtype_reg <= 8'd0;
            vals_reg  <= '0;
            found_reg <= '0;
        end else if (byte_fire) begin
            if (last_byte) begin
                phase_reg <= dhcp_tlv_pkg::PH_TYPE;
                opt_reg   <= 8'd0;
                len_reg   <= 8'd0;
                seen_reg  <= 8'd0;
                acc_reg   <= 32'd0;
                mtype_reg <= 8'd0;
                vals_reg  <= '0;
                found_reg <= '0;
            end else begin
                phase_reg <= phase_next;
                opt_reg   <= opt_next;
                len_reg   <= len_next;
                seen_reg  <= seen_next;
                acc_reg   <= acc_next;
                mtype_reg <= mtype_next;
                vals_reg  <= vals_next;
                found_reg <= found_next;
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/dhcp_tlv_out_buf.sv
// Two-entry result buffer: output register plus a skid register.
// Depends on dhcp_tlv_pkg for the result struct and status type.
`default_nettype none

module dhcp_tlv_out_buf (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     push,
    input  wire dhcp_tlv_pkg::result_t    push_data,
    output logic                          can_push,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output dhcp_tlv_pkg::result_t         out_data,
    output dhcp_tlv_pkg::buf_status_t     status
);

    logic                  out_valid_reg, out_valid_next;
    logic                  skid_valid_reg, skid_valid_next;
    dhcp_tlv_pkg::result_t out_data_reg, out_data_next;
    dhcp_tlv_pkg::result_t skid_data_reg, skid_data_next;
    logic                  out_free;

    // Results move out of the skid first so order is kept.
    always_comb
    begin
        out_free        = !out_valid_reg || out_ready;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (out_free) begin
            if (skid_valid_reg) begin
                out_data_next   = skid_data_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else if (push) begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end else begin
                out_valid_next = 1'b0;
            end
        end else if (push) begin
            skid_data_next  = push_data;
            skid_valid_next = 1'b1;
        end
    end

    // Control bits take reset; payload does not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign can_push          = !skid_valid_reg;
    assign out_valid         = out_valid_reg;
    assign out_data          = out_data_reg;
    assign status.out_valid  = out_valid_reg;
    assign status.skid_valid = skid_valid_reg;

endmodule

`default_nettype wire

>>> hdl/dhcp_option_tlv_parser_top.sv
// Top level of the DHCP options TLV parser: stream ports, core and result buffer.
// Depends on dhcp_tlv_pkg, dhcp_tlv_core and dhcp_tlv_out_buf.
//
//  Channel   Direction  Transaction                     Payload
//  s_axis    in         one byte of the options area    tdata = data_byte, tlast = last_byte
//  m_axis    out        one parsed options area         tdata = packed result, see port
//
// One byte is taken per cycle while s_axis_tready is high; the walker state updates in the same cycle.
// A result enters the buffer as the byte with tlast is taken, behind any result held there.
// Reset returns the walker to expect an option code and empties the buffer.
// The buffer holds two results, so s_axis keeps flowing while one result
// waits; s_axis_tready drops only when both entries are full.
`default_nettype none

module dhcp_option_tlv_parser_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tlast,   // last_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] message_type, [39:8] subnet_value, [71:40] router_value,
    // [103:72] dns_value, [135:104] lease_seconds, [167:136] server_id_value,
    // [199:168] renew_seconds, [231:200] rebind_seconds, [238:232] found_mask,
    // [239] zero
    output logic [dhcp_tlv_pkg::RESULT_TDATA_BITS-1:0] m_axis_tdata
);

    logic                      s_fire;
    logic                      res_valid;
    dhcp_tlv_pkg::result_t     res_data;
    dhcp_tlv_pkg::result_t     out_data;
    dhcp_tlv_pkg::phase_t      phase;
    dhcp_tlv_pkg::buf_status_t buf_status;
    logic                      can_push;

    assign s_axis_tready = can_push;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    // Record walker.
    dhcp_tlv_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_fire (s_fire),
        .data_byte (s_axis_tdata),
        .last_byte (s_axis_tlast),
        .res_valid (res_valid),
        .res_data  (res_data),
        .phase     (phase)
    );

    // Result buffer.
    dhcp_tlv_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res_data),
        .can_push  (can_push),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_data),
        .status    (buf_status)
    );

    // The struct packs in stream order; pad the top up to whole bytes.
    assign m_axis_tdata = {
        {(dhcp_tlv_pkg::RESULT_TDATA_BITS - dhcp_tlv_pkg::RESULT_BITS){1'b0}},
        out_data
    };

    // A waiting skid entry always has an occupied output register ahead of it.
    assert property (@(posedge clk) disable iff (!rst_n)
        buf_status.skid_valid |-> buf_status.out_valid)
        else $error("skid entry held with empty output register");

    // A new result on the output follows a final byte taken the cycle before.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_fire && s_axis_tlast))
        else $error("result appeared without a final byte");

    // After a final byte the walker restarts at an option code.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && s_axis_tlast) |=> (phase == dhcp_tlv_pkg::PH_TYPE))
        else $error("walker not restarted after final byte");

endmodule

`default_nettype wire
